FILE: hw/rtl/sgls_pkg.sv
// Package for the sequence gap link store: widths, codes and the control program.
`timescale 1ns / 1ps
`default_nettype none

package sgls_pkg;

	// Default array size and symbol width.
	localparam int ENTRY_COUNT_DEF = 4096;
	localparam int SYMBOL_BITS_DEF = 31;

	// Fixed port widths.
	localparam int OP_W = 2;
	localparam int POS_W = 12;
	localparam int SYM_PORT_W = 31;
	localparam int LINK_PORT_W = 13;

	// Reset value of the last-entry register.
	localparam logic [POS_W-1:0] LAST_INDEX_RESET = 12'd4095;

	// Operation codes; the unused code behaves as a read.
	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	// Program step addresses.
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] S_CLR = 5'd0;
	localparam logic [STEP_W-1:0] S_IDLE = 5'd1;
	localparam logic [STEP_W-1:0] S_RED0 = 5'd2;
	localparam logic [STEP_W-1:0] S_RED1 = 5'd3;
	localparam logic [STEP_W-1:0] S_RED2 = 5'd4;
	localparam logic [STEP_W-1:0] S_LOAD = 5'd5;
	localparam logic [STEP_W-1:0] S_DEL0 = 5'd6;
	localparam logic [STEP_W-1:0] S_DEL1 = 5'd7;
	localparam logic [STEP_W-1:0] S_DEL2 = 5'd8;
	localparam logic [STEP_W-1:0] S_C00 = 5'd9;
	localparam logic [STEP_W-1:0] S_C01A = 5'd10;
	localparam logic [STEP_W-1:0] S_C10A = 5'd11;
	localparam logic [STEP_W-1:0] S_C11A = 5'd12;
	localparam logic [STEP_W-1:0] S_C11B = 5'd13;
	localparam logic [STEP_W-1:0] S_C11C = 5'd14;
	localparam logic [STEP_W-1:0] S_C01B = 5'd15;
	localparam logic [STEP_W-1:0] S_C10B = 5'd16;
	localparam logic [STEP_W-1:0] S_OUT0 = 5'd17;
	localparam logic [STEP_W-1:0] S_OUT1 = 5'd18;

	// Sequencer jump kinds.
	localparam logic [3:0] J_NEXT = 4'd0;
	localparam logic [3:0] J_ALWAYS = 4'd1;
	localparam logic [3:0] J_IDLE = 4'd2;
	localparam logic [3:0] J_CLR = 4'd3;
	localparam logic [3:0] J_OP = 4'd4;
	localparam logic [3:0] J_POS0 = 4'd5;
	localparam logic [3:0] J_POSDEL = 4'd6;
	localparam logic [3:0] J_CASE = 4'd7;
	localparam logic [3:0] J_OUT = 4'd8;

	// Read port A address select.
	localparam logic [1:0] RA_OFF = 2'd0;
	localparam logic [1:0] RA_POS = 2'd1;
	localparam logic [1:0] RA_PREV = 2'd2;

	// Back link write address and data selects.
	localparam logic [1:0] BA_OFF = 2'd0;
	localparam logic [1:0] BA_POS = 2'd1;
	localparam logic [1:0] BA_PREV = 2'd2;
	localparam logic [1:0] BA_RUN_END = 2'd3;
	localparam logic [1:0] BD_NONE = 2'd0;
	localparam logic [1:0] BD_PREV = 2'd1;
	localparam logic [1:0] BD_PREV_BACK = 2'd2;

	// Forward link write address and data selects.
	localparam logic [1:0] FA_OFF = 2'd0;
	localparam logic [1:0] FA_POS = 2'd1;
	localparam logic [1:0] FA_NEXT = 2'd2;
	localparam logic [1:0] FA_RUN_START = 2'd3;
	localparam logic [1:0] FD_NONE = 2'd0;
	localparam logic [1:0] FD_NEXT = 2'd1;
	localparam logic [1:0] FD_NEXT_FWD = 2'd2;

	// Deleted mark write at the addressed entry.
	localparam logic [1:0] DM_OFF = 2'd0;
	localparam logic [1:0] DM_SET = 2'd1;
	localparam logic [1:0] DM_CLEAR = 2'd2;

	// One control word of the program.
	typedef struct packed {
		logic [STEP_W-1:0] target;
		logic [3:0] jump;
		logic [1:0] rda;
		logic rdb;
		logic [1:0] ba;
		logic [1:0] bd;
		logic [1:0] fa;
		logic [1:0] fd;
		logic [1:0] dm;
		logic sym_wr;
		logic idx_ld;
		logic clr;
		logic out_ld;
	} ucode_t;

	// Control program: one word per step.
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = '0;
		case (step)
			S_CLR: begin
				w.clr = 1'b1;
				w.jump = J_CLR;
			end
			S_IDLE: begin
				w.jump = J_IDLE;
			end
			S_RED0, S_RED1: begin
				w.jump = J_NEXT;
			end
			S_RED2: begin
				w.idx_ld = 1'b1;
				w.jump = J_OP;
			end
			S_LOAD: begin
				w.sym_wr = 1'b1;
				w.dm = DM_CLEAR;
				w.ba = BA_POS;
				w.bd = BD_NONE;
				w.fa = FA_POS;
				w.fd = FD_NONE;
				w.jump = J_ALWAYS;
				w.target = S_OUT0;
			end
			S_DEL0: begin
				w.rda = RA_POS;
				w.rdb = 1'b1;
				w.jump = J_POS0;
				w.target = S_OUT0;
			end
			S_DEL1: begin
				w.rda = RA_PREV;
				w.jump = J_POSDEL;
				w.target = S_OUT0;
			end
			S_DEL2: begin
				w.jump = J_CASE;
				w.target = S_C00;
			end
			S_C00: begin
				w.ba = BA_POS;
				w.bd = BD_PREV;
				w.fa = FA_POS;
				w.fd = FD_NEXT;
				w.dm = DM_SET;
				w.jump = J_ALWAYS;
				w.target = S_OUT0;
			end
			S_C01A: begin
				w.fa = FA_POS;
				w.fd = FD_NEXT_FWD;
				w.ba = BA_RUN_END;
				w.bd = BD_PREV;
				w.jump = J_ALWAYS;
				w.target = S_C01B;
			end
			S_C10A: begin
				w.ba = BA_POS;
				w.bd = BD_PREV_BACK;
				w.fa = FA_RUN_START;
				w.fd = FD_NEXT;
				w.jump = J_ALWAYS;
				w.target = S_C10B;
			end
			S_C11A: begin
				w.ba = BA_RUN_END;
				w.bd = BD_PREV_BACK;
				w.fa = FA_RUN_START;
				w.fd = FD_NEXT_FWD;
				w.jump = J_NEXT;
			end
			S_C11B: begin
				w.ba = BA_PREV;
				w.bd = BD_NONE;
				w.fa = FA_NEXT;
				w.fd = FD_NONE;
				w.jump = J_NEXT;
			end
			S_C11C: begin
				w.ba = BA_POS;
				w.bd = BD_NONE;
				w.fa = FA_POS;
				w.fd = FD_NONE;
				w.dm = DM_SET;
				w.jump = J_ALWAYS;
				w.target = S_OUT0;
			end
			S_C01B: begin
				w.fa = FA_NEXT;
				w.fd = FD_NONE;
				w.ba = BA_POS;
				w.bd = BD_NONE;
				w.dm = DM_SET;
				w.jump = J_ALWAYS;
				w.target = S_OUT0;
			end
			S_C10B: begin
				w.ba = BA_PREV;
				w.bd = BD_NONE;
				w.fa = FA_POS;
				w.fd = FD_NONE;
				w.dm = DM_SET;
				w.jump = J_ALWAYS;
				w.target = S_OUT0;
			end
			S_OUT0: begin
				w.rda = RA_POS;
				w.jump = J_NEXT;
			end
			S_OUT1: begin
				w.out_ld = 1'b1;
				w.jump = J_OUT;
				w.target = S_IDLE;
			end
			default: begin
				w.jump = J_ALWAYS;
				w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sequence_gap_link_store_unit.sv
// Top level of the sequence gap link store: sequencer, link memories and result register.
// Usage:
// The block holds an array of sequence entries, each with a symbol, a kind bit, a deleted
// mark and back and forward gap links. The input channel (in_valid, in_stall) carries one
// transaction per operation: load, delete or read of the entry at position. The output
// channel (out_valid, out_stall) returns one transaction per operation with a status and
// the addressed entry as it stands afterwards. The user must write the last_index register
// through cfg_wr_en and cfg_wr_data while the block is idle; the block does not enforce it.
// A small control program steps through every operation: the steps S_RED0, S_RED1 and
// S_RED2 reduce the position and last_index into the array range, then the operation runs
// over the single-write link memories. A read goes straight to the result steps, a load
// first writes the entry, and a delete checks for entry 0 and for an already deleted entry,
// then rewrites the links in steps that depend on the neighbor case. No new transaction is
// taken until the result step has passed; the number of write ports of the link memories
// sets the length of a delete.
// After reset a clearing pass writes every entry's mark and links with in_stall held high;
// configuration writes are taken during it. While the receiver stalls, the result register
// holds and the next transaction is still taken and processed up to its result step, which
// waits until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module sequence_gap_link_store_unit #(
	parameter int ENTRY_COUNT = sgls_pkg::ENTRY_COUNT_DEF,
	parameter int SYMBOL_BITS = sgls_pkg::SYMBOL_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [sgls_pkg::POS_W-1:0] cfg_wr_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [sgls_pkg::OP_W-1:0] opcode,
	input wire logic [sgls_pkg::POS_W-1:0] position,
	input wire logic [sgls_pkg::SYM_PORT_W-1:0] symbol,
	input wire logic is_punctuation,
	output logic out_valid,
	input wire logic out_stall,
	output logic status,
	output logic [sgls_pkg::SYM_PORT_W-1:0] entry_symbol,
	output logic entry_punctuation,
	output logic entry_deleted,
	output logic [sgls_pkg::LINK_PORT_W-1:0] back_link,
	output logic [sgls_pkg::LINK_PORT_W-1:0] forward_link
);

	localparam int IDX_W = $clog2(ENTRY_COUNT);
	localparam int LINK_W = $clog2(ENTRY_COUNT + 1);
	localparam int POS_W = sgls_pkg::POS_W;
	localparam int RED_K = 2 * POS_W;
	localparam int RECIP_W = RED_K;
	localparam int PROD_W = POS_W + RECIP_W;
	localparam int QN_W = POS_W + LINK_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RED_K) / ENTRY_COUNT);
	localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(ENTRY_COUNT);
	localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(ENTRY_COUNT - 1);
	localparam int STEP_W = sgls_pkg::STEP_W;

	// Sequencer state and current control word.
	logic [STEP_W-1:0] upc_q;
	logic [STEP_W-1:0] upc_d;
	sgls_pkg::ucode_t uc;
	logic accept;
	logic out_busy;
	logic out_load;

	// Accepted transaction and configuration.
	logic [sgls_pkg::OP_W-1:0] op_q;
	logic [POS_W-1:0] pos_raw_q;
	logic [SYMBOL_BITS-1:0] sym_q;
	logic punc_q;
	logic [POS_W-1:0] last_index_q;
	logic status_q;

	// Range reduction.
	logic [POS_W-1:0] red_in [2];
	logic [PROD_W-1:0] prod_s1 [2];
	logic [POS_W-1:0] qn_s2 [2];
	logic [POS_W-1:0] red_out [2];
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] end_q;
	logic [IDX_W-1:0] clr_q;

	// Neighbors and run ends.
	logic [IDX_W-1:0] prev_idx;
	logic [IDX_W-1:0] next_idx;
	logic [LINK_W-1:0] pos_inc;
	logic [LINK_W:0] rs_sum;
	logic rs_live;
	logic re_live;
	logic [IDX_W-1:0] re_addr;

	// Memories and their ports.
	logic [SYMBOL_BITS:0] sym_mem [ENTRY_COUNT];
	logic del_mem [ENTRY_COUNT];
	logic [LINK_W-1:0] back_mem [ENTRY_COUNT];
	logic [LINK_W-1:0] fwd_mem [ENTRY_COUNT];
	logic [SYMBOL_BITS:0] sym_rd_a;
	logic del_rd_a;
	logic del_rd_b;
	logic [LINK_W-1:0] back_rd_a;
	logic [LINK_W-1:0] fwd_rd_a;
	logic [LINK_W-1:0] fwd_rd_b;
	logic rda_en;
	logic [IDX_W-1:0] rda_addr;
	logic back_we;
	logic [IDX_W-1:0] back_wa;
	logic [LINK_W-1:0] back_wd;
	logic fwd_we;
	logic [IDX_W-1:0] fwd_wa;
	logic [LINK_W-1:0] fwd_wd;
	logic del_we;
	logic [IDX_W-1:0] del_wa;
	logic del_wd;
	logic sym_we;

	// Output register.
	logic out_valid_q;
	logic [SYMBOL_BITS:0] out_sym_q;
	logic out_del_q;
	logic [LINK_W-1:0] out_back_q;
	logic [LINK_W-1:0] out_fwd_q;
	logic out_status_q;

	// Handshake decode.
	assign uc = sgls_pkg::ucode_rom(upc_q);
	assign in_stall = (upc_q != sgls_pkg::S_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_busy = out_valid_q && out_stall;
	assign out_load = uc.out_ld && !out_busy;

	// Next step selection.
	always_comb begin
		case (uc.jump)
			sgls_pkg::J_NEXT: upc_d = upc_q + STEP_W'(1);
			sgls_pkg::J_ALWAYS: upc_d = uc.target;
			sgls_pkg::J_IDLE: upc_d = accept ? upc_q + STEP_W'(1) : upc_q;
			sgls_pkg::J_CLR: upc_d = (clr_q == CLR_LAST) ? upc_q + STEP_W'(1) : upc_q;
			sgls_pkg::J_OP: begin
				case (op_q)
					sgls_pkg::OP_LOAD: upc_d = sgls_pkg::S_LOAD;
					sgls_pkg::OP_DELETE: upc_d = sgls_pkg::S_DEL0;
					default: upc_d = sgls_pkg::S_OUT0;
				endcase
			end
			sgls_pkg::J_POS0: upc_d = (pos_q == '0) ? uc.target : upc_q + STEP_W'(1);
			sgls_pkg::J_POSDEL: upc_d = del_rd_a ? uc.target : upc_q + STEP_W'(1);
			sgls_pkg::J_CASE: upc_d = uc.target + STEP_W'({del_rd_a, del_rd_b});
			sgls_pkg::J_OUT: upc_d = out_busy ? upc_q : uc.target;
			default: upc_d = sgls_pkg::S_IDLE;
		endcase
	end

	// Step counter, clearing counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= sgls_pkg::S_CLR;
			clr_q <= '0;
			status_q <= 1'b0;
		end else begin
			upc_q <= upc_d;
			if (uc.clr) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (accept) begin
				status_q <= 1'b0;
			end else if (uc.jump == sgls_pkg::J_POS0 && pos_q == '0) begin
				status_q <= 1'b1;
			end
		end
	end

	// The last-entry register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_index_q <= sgls_pkg::LAST_INDEX_RESET;
		end else if (cfg_wr_en) begin
			last_index_q <= cfg_wr_data;
		end
	end

	// Capture of the accepted transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= opcode;
			pos_raw_q <= position;
			sym_q <= symbol[SYMBOL_BITS-1:0];
			punc_q <= is_punctuation;
		end
	end

	// Reduction modulo the array size: reciprocal multiply, back-multiply, one correction.
	assign red_in[0] = pos_raw_q;
	assign red_in[1] = last_index_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			prod_s1[i] <= PROD_W'(red_in[i]) * PROD_W'(RECIP);
			qn_s2[i] <= POS_W'(QN_W'(prod_s1[i][RED_K +: POS_W]) * QN_W'(ENTRY_COUNT));
		end
	end

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			red_out[i] = red_in[i] - qn_s2[i];
			if (QN_W'(red_out[i]) >= QN_W'(ENTRY_COUNT)) begin
				red_out[i] = POS_W'(QN_W'(red_out[i]) - QN_W'(ENTRY_COUNT));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (uc.idx_ld) begin
			pos_q <= IDX_W'(red_out[0]);
			end_q <= IDX_W'(red_out[1]);
		end
	end

	// Neighbors of the addressed entry; the one after the last entry wraps to entry 0.
	assign prev_idx = pos_q - IDX_W'(1);
	assign pos_inc = LINK_W'(pos_q) + LINK_W'(1);
	assign next_idx = (pos_q == end_q || pos_inc >= LINK_NONE) ? '0 : IDX_W'(pos_inc);

	// Run start after the previous neighbor's back link, run end before the next one's forward link.
	assign rs_sum = {1'b0, back_rd_a} + (LINK_W + 1)'(1);
	assign rs_live = rs_sum < (LINK_W + 1)'(ENTRY_COUNT);
	assign re_live = fwd_rd_b < LINK_NONE;
	assign re_addr = (fwd_rd_b == '0) ? end_q : IDX_W'(fwd_rd_b - LINK_W'(1));

	// Read port A address.
	assign rda_en = (uc.rda != sgls_pkg::RA_OFF);
	assign rda_addr = (uc.rda == sgls_pkg::RA_PREV) ? prev_idx : pos_q;

	// Back link write port.
	always_comb begin
		back_we = 1'b0;
		back_wa = pos_q;
		back_wd = LINK_NONE;
		if (uc.clr) begin
			back_we = 1'b1;
			back_wa = clr_q;
		end else begin
			case (uc.ba)
				sgls_pkg::BA_POS: back_we = 1'b1;
				sgls_pkg::BA_PREV: begin
					back_we = 1'b1;
					back_wa = prev_idx;
				end
				sgls_pkg::BA_RUN_END: begin
					back_we = re_live;
					back_wa = re_addr;
				end
				default: back_we = 1'b0;
			endcase
			case (uc.bd)
				sgls_pkg::BD_PREV: back_wd = LINK_W'(prev_idx);
				sgls_pkg::BD_PREV_BACK: back_wd = back_rd_a;
				default: back_wd = LINK_NONE;
			endcase
		end
	end

	// Forward link write port.
	always_comb begin
		fwd_we = 1'b0;
		fwd_wa = pos_q;
		fwd_wd = LINK_NONE;
		if (uc.clr) begin
			fwd_we = 1'b1;
			fwd_wa = clr_q;
		end else begin
			case (uc.fa)
				sgls_pkg::FA_POS: fwd_we = 1'b1;
				sgls_pkg::FA_NEXT: begin
					fwd_we = 1'b1;
					fwd_wa = next_idx;
				end
				sgls_pkg::FA_RUN_START: begin
					fwd_we = rs_live;
					fwd_wa = rs_sum[IDX_W-1:0];
				end
				default: fwd_we = 1'b0;
			endcase
			case (uc.fd)
				sgls_pkg::FD_NEXT: fwd_wd = LINK_W'(next_idx);
				sgls_pkg::FD_NEXT_FWD: fwd_wd = fwd_rd_b;
				default: fwd_wd = LINK_NONE;
			endcase
		end
	end

	// Deleted mark and symbol write ports.
	always_comb begin
		del_wa = uc.clr ? clr_q : pos_q;
		case (uc.dm)
			sgls_pkg::DM_SET: begin
				del_we = 1'b1;
				del_wd = 1'b1;
			end
			sgls_pkg::DM_CLEAR: begin
				del_we = 1'b1;
				del_wd = 1'b0;
			end
			default: begin
				del_we = uc.clr;
				del_wd = 1'b0;
			end
		endcase
	end

	assign sym_we = uc.sym_wr;

	// Memory writes.
	always_ff @(posedge clk) begin
		if (back_we) begin
			back_mem[back_wa] <= back_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (fwd_we) begin
			fwd_mem[fwd_wa] <= fwd_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (del_we) begin
			del_mem[del_wa] <= del_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (sym_we) begin
			sym_mem[pos_q] <= {punc_q, sym_q};
		end
	end

	// Registered reads: port A at the entry or its previous neighbor, port B at the next one.
	always_ff @(posedge clk) begin
		if (rda_en) begin
			sym_rd_a <= sym_mem[rda_addr];
			del_rd_a <= del_mem[rda_addr];
			back_rd_a <= back_mem[rda_addr];
			fwd_rd_a <= fwd_mem[rda_addr];
		end
		if (uc.rdb) begin
			del_rd_b <= del_mem[next_idx];
			fwd_rd_b <= fwd_mem[next_idx];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			out_sym_q <= sym_rd_a;
			out_del_q <= del_rd_a;
			out_back_q <= back_rd_a;
			out_fwd_q <= fwd_rd_a;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign entry_symbol = sgls_pkg::SYM_PORT_W'(out_sym_q[SYMBOL_BITS-1:0]);
	assign entry_punctuation = out_sym_q[SYMBOL_BITS];
	assign entry_deleted = out_del_q;
	assign back_link = sgls_pkg::LINK_PORT_W'(out_back_q);
	assign forward_link = sgls_pkg::LINK_PORT_W'(out_fwd_q);

`ifndef ASSERT_OFF
	// A result appears only from the result step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(upc_q) == sgls_pkg::S_RED0 - sgls_pkg::S_RED0
			+ sgls_pkg::S_OUT1)
		else $error("result register loaded outside the result step");

	// Nothing is written to the memories while waiting for a transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == sgls_pkg::S_IDLE) |-> !(back_we || fwd_we || del_we || sym_we))
		else $error("memory write while idle");

	// A refused status only comes from a delete of entry 0.
	assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == sgls_pkg::S_OUT1 && status_q) |-> (op_q == sgls_pkg::OP_DELETE && pos_q == '0))
		else $error("refused status without a delete of entry 0");

	// Entry 0 is never marked deleted.
	assert property (@(posedge clk) disable iff (!arst_n)
		(del_we && del_wd) |-> (pos_q != '0 && !uc.clr))
		else $error("deleted mark set on entry 0");
`endif

endmodule

`default_nettype wire
